@@ rtl/rfa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_pkg: shared types and constants of the frame allocator
// Frame and count geometry, request codes, beat payloads and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rfa_pkg;

	localparam int unsigned FRAMES     = 1024;
	localparam int unsigned COUNT_BITS = 8;
	localparam int unsigned FRAME_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int unsigned ST_BITS    = COUNT_BITS + 1;

	localparam logic [FRAME_BITS-1:0] FRAME_LAST = FRAME_BITS'(FRAMES - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

	localparam logic [1:0] FUNC_TAKE    = 2'd0;
	localparam logic [1:0] FUNC_RESERVE = 2'd1;
	localparam logic [1:0] FUNC_RETURN  = 2'd2;
	localparam logic [1:0] FUNC_SPARE   = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [9:0] frame_index;
	} req_t;

	typedef struct packed {
		logic [9:0] frame_out;
		logic       status;
		logic [7:0] count_out;
	} rsp_t;

	typedef struct packed {
		logic init_wr;
		logic load;
		logic exec;
		logic link2;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic init_last;
		logic need_link2;
		logic out_free;
	} sts_t;

	function automatic logic [7:0] sat_out(input logic [COUNT_BITS-1:0] c);
		if (32'(c) > 32'd255) begin
			return 8'hFF;
		end
		return 8'(c);
	endfunction

endpackage
`default_nettype wire

@@ rtl/rfa_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/rfa_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_ctrl: allocator sequencer
// Runs the clearing sweep, then steps each request through execute,
// optional second link write and response hand-off.
// ----------------------------------------------------------------------------
module rfa_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire rfa_pkg::sts_t sts,
	output rfa_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_LINK2,
		ST_RESP
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   req_stall_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_INIT:  if (sts.init_last) state_nx = ST_IDLE;
			ST_IDLE:  if (req_valid) state_nx = ST_EXEC;
			ST_EXEC:  state_nx = sts.need_link2 ? ST_LINK2 : ST_RESP;
			ST_LINK2: state_nx = ST_RESP;
			ST_RESP:  if (sts.out_free) state_nx = ST_IDLE;
			default:  state_nx = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			req_stall_q <= 1'b1;
		end else begin
			state_q     <= state_nx;
			req_stall_q <= (state_nx != ST_IDLE);
		end
	end

	assign req_stall   = req_stall_q;
	assign cmd.init_wr = (state_q == ST_INIT);
	assign cmd.load    = (state_q == ST_IDLE) && req_valid;
	assign cmd.exec    = (state_q == ST_EXEC);
	assign cmd.link2   = (state_q == ST_LINK2);
	assign cmd.push    = (state_q == ST_RESP) && sts.out_free;

endmodule
`default_nettype wire

@@ rtl/rfa_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_dp: allocator datapath
// Link and count memories, head and empty flag, request latch,
// unlink and insert write selection and the response register.
// ----------------------------------------------------------------------------
module rfa_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rfa_pkg::req_t req,
	input  wire rfa_pkg::cmd_t cmd,
	output rfa_pkg::sts_t      sts,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output rfa_pkg::rsp_t      rsp
);

	localparam int unsigned FB = rfa_pkg::FRAME_BITS;
	localparam int unsigned CB = rfa_pkg::COUNT_BITS;
	localparam int unsigned SB = rfa_pkg::ST_BITS;

	logic [FB-1:0] init_q;
	logic [FB-1:0] head_q;
	logic          empty_q;
	logic [FB-1:0] f_q;
	logic [1:0]    func_q;
	logic [9:0]    idx_q;
	logic          bad_q;
	rfa_pkg::rsp_t res_q;
	rfa_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;

	logic [FB-1:0] sel_f;
	logic [FB-1:0] nxt_raddr;
	logic [FB-1:0] rd_nxt;
	logic [FB-1:0] rd_prv;
	logic [SB-1:0] rd_st;

	logic          nxt_we, prv_we, st_we;
	logic [FB-1:0] nxt_waddr, nxt_wdata, prv_waddr, prv_wdata, st_waddr;
	logic [SB-1:0] st_wdata;

	logic          st_on;
	logic [CB-1:0] st_cnt, cnt_inc, cnt_dec;
	logic          is_take, is_res, is_ret, take_empty, do_res, do_ret, ins;
	rfa_pkg::rsp_t res_nx;

	assign sel_f     = (req.func == rfa_pkg::FUNC_TAKE) ? head_q : FB'(req.frame_index);
	assign nxt_raddr = (req.func == rfa_pkg::FUNC_RETURN) ? head_q : sel_f;

	assign st_on   = rd_st[CB];
	assign st_cnt  = rd_st[CB-1:0];
	assign cnt_inc = (st_cnt == rfa_pkg::COUNT_MAX) ? st_cnt : CB'(st_cnt + 1'b1);
	assign cnt_dec = CB'(st_cnt - 1'b1);

	assign is_take    = (func_q == rfa_pkg::FUNC_TAKE);
	assign is_res     = (func_q == rfa_pkg::FUNC_RESERVE);
	assign is_ret     = (func_q == rfa_pkg::FUNC_RETURN);
	assign take_empty = is_take && empty_q;
	assign do_res     = (is_take && !empty_q) || (is_res && !bad_q);
	assign do_ret     = is_ret && !bad_q && (st_cnt != '0);
	assign ins        = do_ret && (cnt_dec == '0) && !st_on;

	always_comb begin
		res_nx.frame_out = take_empty ? 10'd0 : (is_take ? 10'(f_q) : idx_q);
		res_nx.status    = !(do_res || do_ret);
		res_nx.count_out = do_res ? rfa_pkg::sat_out(cnt_inc)
			: (do_ret ? rfa_pkg::sat_out(cnt_dec) : 8'd0);
	end

	always_comb begin
		nxt_we    = 1'b0;
		nxt_waddr = f_q;
		nxt_wdata = f_q;
		prv_we    = 1'b0;
		prv_waddr = f_q;
		prv_wdata = f_q;
		st_we     = 1'b0;
		st_waddr  = f_q;
		st_wdata  = {1'b0, cnt_inc};
		if (cmd.init_wr) begin
			nxt_we    = 1'b1;
			nxt_waddr = init_q;
			nxt_wdata = (init_q == rfa_pkg::FRAME_LAST) ? '0 : FB'(init_q + 1'b1);
			prv_we    = 1'b1;
			prv_waddr = init_q;
			prv_wdata = (init_q == '0) ? rfa_pkg::FRAME_LAST : FB'(init_q - 1'b1);
			st_we     = 1'b1;
			st_waddr  = init_q;
			st_wdata  = {1'b1, {CB{1'b0}}};
		end else if (cmd.exec) begin
			if (do_res) begin
				st_we    = 1'b1;
				st_wdata = {1'b0, cnt_inc};
				if (st_on) begin
					nxt_we    = 1'b1;
					nxt_waddr = rd_prv;
					nxt_wdata = rd_nxt;
					prv_we    = 1'b1;
					prv_waddr = rd_nxt;
					prv_wdata = rd_prv;
				end
			end
			if (do_ret) begin
				st_we    = 1'b1;
				st_wdata = {st_on || (cnt_dec == '0), cnt_dec};
			end
			if (ins) begin
				nxt_we    = 1'b1;
				nxt_waddr = f_q;
				nxt_wdata = empty_q ? f_q : rd_nxt;
				prv_we    = 1'b1;
				prv_waddr = empty_q ? f_q : rd_nxt;
				prv_wdata = f_q;
			end
		end else if (cmd.link2) begin
			nxt_we    = 1'b1;
			nxt_waddr = head_q;
			nxt_wdata = f_q;
			prv_we    = 1'b1;
			prv_waddr = f_q;
			prv_wdata = head_q;
		end
	end

	rfa_ram #(.WIDTH(FB), .DEPTH(rfa_pkg::FRAMES)) u_nxt (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.raddr (nxt_raddr),
		.rdata (rd_nxt)
	);

	rfa_ram #(.WIDTH(FB), .DEPTH(rfa_pkg::FRAMES)) u_prv (
		.clk   (clk),
		.we    (prv_we),
		.waddr (prv_waddr),
		.wdata (prv_wdata),
		.raddr (sel_f),
		.rdata (rd_prv)
	);

	rfa_ram #(.WIDTH(SB), .DEPTH(rfa_pkg::FRAMES)) u_st (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (sel_f),
		.rdata (rd_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q      <= '0;
			head_q      <= '0;
			empty_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.init_wr) begin
				init_q <= FB'(init_q + 1'b1);
			end
			if (cmd.exec && do_res && st_on && (head_q == f_q)) begin
				if (rd_nxt != f_q) begin
					head_q <= rd_nxt;
				end else begin
					empty_q <= 1'b1;
				end
			end
			if (cmd.exec && ins && empty_q) begin
				head_q  <= f_q;
				empty_q <= 1'b0;
			end
			rsp_valid_q <= cmd.push || (rsp_valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= req.func;
			idx_q  <= req.frame_index;
			f_q    <= sel_f;
			bad_q  <= (req.func == rfa_pkg::FUNC_SPARE)
				|| (32'(req.frame_index) >= rfa_pkg::FRAMES);
		end
		if (cmd.exec) begin
			res_q <= res_nx;
		end
		if (cmd.push) begin
			rsp_q <= res_q;
		end
	end

	assign sts.init_last  = (init_q == rfa_pkg::FRAME_LAST);
	assign sts.need_link2 = ins && !empty_q;
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;
	assign rsp_valid      = rsp_valid_q;
	assign rsp            = rsp_q;

endmodule
`default_nettype wire

@@ rtl/refcounted_frame_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_frame_allocator: reference-counted page-frame allocator
// Free list kept as a circular doubly linked list with a head, plus a
// reference count per frame.
//
// Request channel (req_valid/req_stall/req): func selects take, reserve
// or return; frame_index names the frame for reserve and return.
// Response channel (rsp_valid/rsp_stall/rsp): one beat per request with
// the frame, a status bit and the count after the operation.
// One request is in flight at a time. After acceptance a request steps
// through execute and response hand-off, with a second link write in
// between when a return puts its frame back into a non-empty list; these
// steps are set by the registered reads and the single write port of the
// link memories.
// After reset the block sweeps all FRAMES entries of the link and count
// memories with req_stall high, then takes requests.
// The response sits in an output register; while rsp_stall is high it
// holds, and the block still accepts and executes the next request,
// then waits with req_stall high until the register is free.
// ----------------------------------------------------------------------------
module refcounted_frame_allocator (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire rfa_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output rfa_pkg::rsp_t      rsp
);

	rfa_pkg::cmd_t cmd;
	rfa_pkg::sts_t sts;

	rfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rfa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

@@ rtl/rfa_check.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_check: port checker for the frame allocator
// Flags sequencing slips and nonzero fail counts on both top-level channels.
// ----------------------------------------------------------------------------
module rfa_check (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire rfa_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire rfa_pkg::rsp_t rsp
);

	logic req_beat;

	assign req_beat = req_valid && !req_stall;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat dropped or changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat |=> req_stall)
		else $error("request accepted while another is in flight");

	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat |=> !$rose(rsp_valid))
		else $error("response raised in the cycle after acceptance");

	a_fail_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> rsp.count_out == 8'd0)
		else $error("failed request reports a nonzero count");

endmodule

bind refcounted_frame_allocator rfa_check u_rfa_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire
